// ----- rtl/core/scaled_decimal_alu_macros.svh -----
// ----------------------------------------------------------------------------
// Scaled decimal ALU assertion macros
// Shorthand for the concurrent checks used in the ALU modules.
// ----------------------------------------------------------------------------
`ifndef SCALED_DECIMAL_ALU_MACROS_SVH
`define SCALED_DECIMAL_ALU_MACROS_SVH

// Check that a condition holds in the same cycle as its trigger
`define SDA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition holds in the cycle after its trigger
`define SDA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/sda_pkg.sv -----
// ----------------------------------------------------------------------------
// Scaled decimal ALU package
// Datapath widths, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sda_pkg;

  // Magnitude datapath width: holds a 128-bit operand times 10^36
  localparam int W  = 256;
  localparam int CW = $clog2(W);
  localparam int MW = 128;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MUL   = 4'd2,
    OP_DIV   = 4'd3,
    OP_MOD   = 4'd4,
    OP_GT    = 4'd5,
    OP_LT    = 4'd6,
    OP_LE    = 4'd7,
    OP_GE    = 4'd8,
    OP_EQ    = 4'd9,
    OP_NE    = 4'd10,
    OP_ROUND = 4'd11,
    OP_NEG   = 4'd12,
    OP_ABS   = 4'd13
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_ZDIV = 2'd2,
    ST_UNK  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCALE,
    S_ADD,
    S_SUB2,
    S_CMP,
    S_MUL,
    S_DIV,
    S_RND_CMP,
    S_RND_INC,
    S_TRIM,
    S_CHECK,
    S_DONE
  } state_e;

  // Power of ten at full datapath width, for elaboration-time constants
  function automatic logic [W-1:0] pow10_f(input int unsigned n);
    logic [W-1:0] v;
    v = W'(1);
    for (int unsigned i = 0; i < n; i++) begin
      v = (v << 3) + (v << 1);
    end
    return v;
  endfunction

endpackage

// ----- rtl/core/scaled_decimal_alu.sv -----
// ----------------------------------------------------------------------------
// Scaled decimal ALU
// Fixed-scale decimal arithmetic on 128-bit mantissas with a shared adder.
// ----------------------------------------------------------------------------
// Usage: drive the operands and operation, raise start while busy is low;
// the operands transfer on that edge and busy rises. One result transfers
// per operation: done_o is high for exactly one cycle with r_mant_hi_o,
// r_mant_lo_o, r_scale_o and status_o, and busy drops in the next cycle.
// The receiver cannot stall; results must be taken in the done_o cycle.
// Every step runs through one 256-bit adder/subtractor under a sequencer.
// Sequence per operation (d = scale difference, k = decimal digits padded
// or dropped): add, sub and compare multiply the smaller-scale operand by
// ten d times, then add or compare; neg and abs go straight to the range
// check; mul shifts and adds, then divides by 10^k and rounds when the
// product scale exceeds the limit; mod aligns, then divides; round pads by
// ten k times, or divides by 10^k and rounds; div scales the dividend,
// divides, rounds, then drops trailing zeros. A zero divisor or an unknown
// operation goes straight to done. One operation at a time: the next
// transfer is taken from the cycle after done_o. The divider is a
// restoring divider, one quotient bit per cycle.
// Reset returns the sequencer to idle; no result is pending after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scaled_decimal_alu import sda_pkg::*; #(
  parameter int MAX_SCALE  = 18,
  parameter int MAX_DIGITS = 38
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         operation_i,
  input  logic signed [63:0] a_mant_hi_i,
  input  logic [63:0]        a_mant_lo_i,
  input  logic [4:0]         a_scale_i,
  input  logic signed [63:0] b_mant_hi_i,
  input  logic [63:0]        b_mant_lo_i,
  input  logic [4:0]         b_scale_i,
  input  logic [4:0]         round_places_i,
  output logic               done_o,
  output logic signed [63:0] r_mant_hi_o,
  output logic [63:0]        r_mant_lo_o,
  output logic [4:0]         r_scale_o,
  output logic [1:0]         status_o
);

`include "scaled_decimal_alu_macros.svh"

  localparam logic [4:0]   MAXS  = 5'(MAX_SCALE);
  localparam logic [W-1:0] LIMIT = pow10_f(MAX_DIGITS);

  state_e          state_q, state_d;
  op_e             op_q, op_d;
  logic [W-1:0]    x_q, x_d, y_q, y_d, q_q, q_d, r_q, r_d, res_q, res_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [5:0]      k_q, k_d;
  logic            sel_y_q, sel_y_d, pad_q, pad_d, trim_q, trim_d, inc_q, inc_d;
  logic            an_q, an_d, bn_q, bn_d, rneg_q, rneg_d;
  logic [4:0]      rs_q, rs_d, mins_q, mins_d;
  logic [MW-1:0]   omant_q, omant_d;
  logic [4:0]      oscale_q, oscale_d;
  status_e         ostat_q, ostat_d;

  // Shared unit
  logic [W-1:0]    ua, ub, usum;
  logic            usub, ucarry;

  // Operand decode
  op_e             op_in;
  logic [MW-1:0]   a_raw, b_raw, am, bm;
  logic [4:0]      sa, sb, rp;
  logic [5:0]      sab;
  logic            b_zero;
  logic [W-1:0]    rr, vsel, q_next, r_next;
  logic            cnt_last, as_n, bs_n, eqm, gtm, ltm, c_gt, c_lt, c_eq, c_bit;
  logic            r_clear;

  sda_addsub u_addsub (
    .a_i     (ua),
    .b_i     (ub),
    .sub_i   (usub),
    .sum_o   (usum),
    .carry_o (ucarry)
  );

  // Decode the incoming operands into sign and magnitude
  always_comb begin
    op_in  = op_e'(operation_i);
    a_raw  = {a_mant_hi_i, a_mant_lo_i};
    b_raw  = {b_mant_hi_i, b_mant_lo_i};
    am     = a_raw[MW-1] ? (~a_raw + MW'(1)) : a_raw;
    bm     = b_raw[MW-1] ? (~b_raw + MW'(1)) : b_raw;
    b_zero = (b_raw == '0);
    sa     = (a_scale_i > MAXS) ? MAXS : a_scale_i;
    sb     = (b_scale_i > MAXS) ? MAXS : b_scale_i;
    rp     = (round_places_i > MAXS) ? MAXS : round_places_i;
    sab    = 6'(sa) + 6'(sb);
  end

  // Shared-unit helpers
  assign cnt_last = (cnt_q == '0);
  assign rr       = {r_q[W-2:0], x_q[W-1]};
  assign vsel     = sel_y_q ? y_q : x_q;
  assign q_next   = y_q[0] ? usum : q_q;
  assign r_next   = ucarry ? usum : rr;

  // Signed compare from the difference of the aligned magnitudes
  always_comb begin
    as_n  = an_q & (|x_q);
    bs_n  = bn_q & (|y_q);
    eqm   = (usum == '0);
    gtm   = ucarry & ~eqm;
    ltm   = ~ucarry;
    c_gt  = (as_n != bs_n) ? ~as_n : (as_n ? ltm : gtm);
    c_lt  = (as_n != bs_n) ? as_n : (as_n ? gtm : ltm);
    c_eq  = (as_n == bs_n) & eqm;
    case (op_q)
      OP_GT:   c_bit = c_gt;
      OP_LT:   c_bit = c_lt;
      OP_LE:   c_bit = ~c_gt;
      OP_GE:   c_bit = ~c_lt;
      OP_EQ:   c_bit = c_eq;
      OP_NE:   c_bit = ~c_eq;
      default: c_bit = 1'b0;
    endcase
  end

  // Route operands to the shared unit
  always_comb begin
    ua   = x_q;
    ub   = y_q;
    usub = 1'b0;
    case (state_q)
      S_SCALE: begin
        ua = vsel << 3;
        ub = vsel << 1;
      end
      S_ADD: begin
        usub = (an_q != bn_q);
      end
      S_SUB2: begin
        ua   = y_q;
        ub   = x_q;
        usub = 1'b1;
      end
      S_CMP: begin
        usub = 1'b1;
      end
      S_MUL: begin
        ua = q_q;
        ub = x_q;
      end
      S_DIV: begin
        ua   = rr;
        usub = 1'b1;
      end
      S_RND_CMP: begin
        ua   = r_q << 1;
        usub = 1'b1;
      end
      S_RND_INC: begin
        ua = q_q;
        ub = W'(inc_q);
      end
      S_CHECK: begin
        ua   = res_q;
        ub   = LIMIT;
        usub = 1'b1;
      end
      default: begin
        ua = x_q;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (op_in)
            OP_ADD, OP_SUB, OP_GT, OP_LT, OP_LE, OP_GE, OP_EQ, OP_NE, OP_ROUND:
              state_d = S_SCALE;
            OP_MOD, OP_DIV: state_d = b_zero ? S_DONE : S_SCALE;
            OP_MUL:         state_d = S_MUL;
            OP_NEG, OP_ABS: state_d = S_CHECK;
            default:        state_d = S_DONE;
          endcase
        end
      end
      S_SCALE: begin
        if (k_q == '0) begin
          case (op_q)
            OP_ADD, OP_SUB:                            state_d = S_ADD;
            OP_GT, OP_LT, OP_LE, OP_GE, OP_EQ, OP_NE:  state_d = S_CMP;
            OP_ROUND:                                  state_d = pad_q ? S_CHECK : S_DIV;
            default:                                   state_d = S_DIV;
          endcase
        end
      end
      S_ADD:     state_d = ((an_q != bn_q) && !ucarry) ? S_SUB2 : S_CHECK;
      S_SUB2:    state_d = S_CHECK;
      S_CMP:     state_d = S_DONE;
      S_MUL: begin
        if (cnt_last) state_d = (k_q != '0) ? S_SCALE : S_CHECK;
      end
      S_DIV: begin
        if (cnt_last) begin
          if (op_q == OP_MOD)  state_d = S_CHECK;
          else if (trim_q)     state_d = S_TRIM;
          else                 state_d = S_RND_CMP;
        end
      end
      S_RND_CMP: state_d = S_RND_INC;
      S_RND_INC: state_d = ((op_q == OP_DIV) && (rs_q > mins_q)) ? S_DIV : S_CHECK;
      S_TRIM: begin
        state_d = ((r_q == '0) && (rs_q > mins_q + 5'd1)) ? S_DIV : S_CHECK;
      end
      S_CHECK:   state_d = S_DONE;
      S_DONE:    state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // Datapath updates
  always_comb begin
    op_d     = op_q;
    x_d      = x_q;
    y_d      = y_q;
    q_d      = q_q;
    r_d      = r_q;
    res_d    = res_q;
    cnt_d    = cnt_q;
    k_d      = k_q;
    sel_y_d  = sel_y_q;
    pad_d    = pad_q;
    trim_d   = trim_q;
    inc_d    = inc_q;
    an_d     = an_q;
    bn_d     = bn_q;
    rneg_d   = rneg_q;
    rs_d     = rs_q;
    mins_d   = mins_q;
    omant_d  = omant_q;
    oscale_d = oscale_q;
    ostat_d  = ostat_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          // Take the operands and set up the sequence for the operation
          op_d     = op_in;
          x_d      = {{(W-MW){1'b0}}, am};
          y_d      = {{(W-MW){1'b0}}, bm};
          q_d      = '0;
          r_d      = '0;
          an_d     = a_raw[MW-1];
          bn_d     = b_raw[MW-1] ^ (op_in == OP_SUB);
          mins_d   = (sa > sb) ? sa : sb;
          trim_d   = 1'b0;
          pad_d    = (sa <= rp);
          sel_y_d  = (sa >= sb);
          k_d      = (sa >= sb) ? 6'(sa - sb) : 6'(sb - sa);
          rs_d     = (sa > sb) ? sa : sb;
          rneg_d   = a_raw[MW-1];
          cnt_d    = '1;
          omant_d  = '0;
          oscale_d = '0;
          ostat_d  = ST_OK;
          case (op_in)
            OP_ADD, OP_SUB, OP_GT, OP_LT, OP_LE, OP_GE, OP_EQ, OP_NE: begin
              rneg_d = a_raw[MW-1];
            end
            OP_MOD: begin
              if (b_zero) ostat_d = ST_ZDIV;
            end
            OP_MUL: begin
              cnt_d  = CW'(MW - 1);
              k_d    = (sab > 6'(MAXS)) ? (sab - 6'(MAXS)) : 6'd0;
              rs_d   = (sab > 6'(MAXS)) ? MAXS : sab[4:0];
              rneg_d = a_raw[MW-1] ^ b_raw[MW-1];
            end
            OP_DIV: begin
              if (b_zero) ostat_d = ST_ZDIV;
              k_d     = 6'(MAXS) + 6'(sb) - 6'(sa);
              sel_y_d = 1'b0;
              rs_d    = MAXS;
              rneg_d  = a_raw[MW-1] ^ b_raw[MW-1];
            end
            OP_ROUND: begin
              rs_d = rp;
              if (sa <= rp) begin
                k_d     = 6'(rp - sa);
                sel_y_d = 1'b0;
              end else begin
                y_d     = W'(1);
                k_d     = 6'(sa - rp);
                sel_y_d = 1'b1;
              end
            end
            OP_NEG: begin
              res_d  = {{(W-MW){1'b0}}, am};
              rneg_d = ~a_raw[MW-1];
              rs_d   = sa;
            end
            OP_ABS: begin
              res_d  = {{(W-MW){1'b0}}, am};
              rneg_d = 1'b0;
              rs_d   = sa;
            end
            default: begin
              ostat_d = ST_UNK;
            end
          endcase
        end
      end
      S_SCALE: begin
        // Multiply the selected value by ten, or hand over when done
        if (k_q != '0) begin
          if (sel_y_q) y_d = usum;
          else         x_d = usum;
          k_d = k_q - 6'd1;
        end else begin
          q_d   = '0;
          r_d   = '0;
          cnt_d = '1;
          if ((op_q == OP_ROUND) && pad_q) res_d = x_q;
        end
      end
      S_ADD: begin
        if ((an_q == bn_q) || ucarry) begin
          res_d  = usum;
          rneg_d = an_q;
        end
      end
      S_SUB2: begin
        res_d  = usum;
        rneg_d = bn_q;
      end
      S_CMP: begin
        omant_d  = MW'(c_bit);
        oscale_d = '0;
        ostat_d  = ST_OK;
      end
      S_MUL: begin
        // Shift-add one multiplier bit per cycle
        q_d   = q_next;
        x_d   = x_q << 1;
        y_d   = y_q >> 1;
        cnt_d = cnt_q - CW'(1);
        if (cnt_last) begin
          if (k_q != '0) begin
            x_d     = q_next;
            y_d     = W'(1);
            sel_y_d = 1'b1;
          end else begin
            res_d = q_next;
          end
        end
      end
      S_DIV: begin
        // Restoring division, one quotient bit per cycle
        r_d   = r_next;
        q_d   = {q_q[W-2:0], ucarry};
        x_d   = x_q << 1;
        cnt_d = cnt_q - CW'(1);
        if (cnt_last && (op_q == OP_MOD)) res_d = r_next;
      end
      S_RND_CMP: begin
        // Twice the remainder against the divisor decides the increment
        inc_d = (ucarry && !eqm) ||
                (ucarry && eqm && ((op_q == OP_ROUND) || q_q[0]));
      end
      S_RND_INC: begin
        res_d = usum;
        if ((op_q == OP_DIV) && (rs_q > mins_q)) begin
          x_d    = usum;
          y_d    = W'(10);
          q_d    = '0;
          r_d    = '0;
          cnt_d  = '1;
          trim_d = 1'b1;
        end
      end
      S_TRIM: begin
        // Drop a trailing zero when the division by ten was exact
        if (r_q == '0) begin
          res_d = q_q;
          rs_d  = rs_q - 5'd1;
          x_d   = q_q;
          q_d   = '0;
          r_d   = '0;
          cnt_d = '1;
        end
      end
      S_CHECK: begin
        ostat_d  = ucarry ? ST_OVF : ST_OK;
        oscale_d = rs_q;
        omant_d  = (rneg_q && (res_q != '0)) ? (~res_q[MW-1:0] + MW'(1)) : res_q[MW-1:0];
      end
      default: begin
        inc_d = inc_q;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    x_q      <= x_d;
    y_q      <= y_d;
    q_q      <= q_d;
    r_q      <= r_d;
    res_q    <= res_d;
    cnt_q    <= cnt_d;
    k_q      <= k_d;
    sel_y_q  <= sel_y_d;
    pad_q    <= pad_d;
    trim_q   <= trim_d;
    inc_q    <= inc_d;
    an_q     <= an_d;
    bn_q     <= bn_d;
    rneg_q   <= rneg_d;
    rs_q     <= rs_d;
    mins_q   <= mins_d;
    omant_q  <= omant_d;
    oscale_q <= oscale_d;
    ostat_q  <= ostat_d;
  end

  // Outputs
  assign busy        = (state_q != S_IDLE);
  assign done_o      = (state_q == S_DONE);
  assign r_mant_hi_o = omant_q[MW-1:64];
  assign r_mant_lo_o = omant_q[63:0];
  assign r_scale_o   = oscale_q;
  assign status_o    = ostat_q;

  // All-zero result fields
  assign r_clear = (r_mant_hi_o == 0) && (r_mant_lo_o == 0) && (r_scale_o == 0);

  `SDA_ASSERT_NXT(a_start_busy, start && !busy, busy, "busy not raised after transfer")
  `SDA_ASSERT_NXT(a_done_once, done_o, !busy && !done_o, "result strobe not single")
  `SDA_ASSERT_IMP(a_zdiv_zero, done_o && (status_o == ST_ZDIV), r_clear, "zero divisor result not cleared")
  `SDA_ASSERT_IMP(a_trim_div, state_q == S_TRIM, (op_q == OP_DIV) && (rs_q > mins_q), "trim outside division")

endmodule

// ----- rtl/core/sda_addsub.sv -----
// ----------------------------------------------------------------------------
// Scaled decimal ALU shared adder
// Full-width add or subtract; carry out on subtract means a >= b.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sda_addsub import sda_pkg::*; (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic         sub_i,
  output logic [W-1:0] sum_o,
  output logic         carry_o
);

  logic [W:0] full;

  // Invert and add one for subtract
  assign full    = {1'b0, a_i} + {1'b0, b_i ^ {W{sub_i}}} + (W+1)'(sub_i);
  assign sum_o   = full[W-1:0];
  assign carry_o = full[W];

endmodule
